/* hw/rtl/hfa_pkg.sv */
`default_nettype none

package hfa_pkg;

    // coefficient format: q1.15
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 15;

    // largest offset magnitude from the centre tap
    localparam int MAX_OFFSET = 63;
    localparam int OFFSET_W   = $clog2(MAX_OFFSET + 1);

    // 2/(pi*m) in q1.15, rounded to nearest, indexed by |m|; zero at even m
    localparam logic signed [COEF_W-1:0] ODD_COEF [MAX_OFFSET+1] = '{
        16'sd0,    16'sd20861, 16'sd0, 16'sd6954, 16'sd0, 16'sd4172, 16'sd0, 16'sd2980,
        16'sd0,    16'sd2318,  16'sd0, 16'sd1896, 16'sd0, 16'sd1605, 16'sd0, 16'sd1391,
        16'sd0,    16'sd1227,  16'sd0, 16'sd1098, 16'sd0, 16'sd993,  16'sd0, 16'sd907,
        16'sd0,    16'sd834,   16'sd0, 16'sd773,  16'sd0, 16'sd719,  16'sd0, 16'sd673,
        16'sd0,    16'sd632,   16'sd0, 16'sd596,  16'sd0, 16'sd564,  16'sd0, 16'sd535,
        16'sd0,    16'sd509,   16'sd0, 16'sd485,  16'sd0, 16'sd464,  16'sd0, 16'sd444,
        16'sd0,    16'sd426,   16'sd0, 16'sd409,  16'sd0, 16'sd394,  16'sd0, 16'sd379,
        16'sd0,    16'sd366,   16'sd0, 16'sd354,  16'sd0, 16'sd342,  16'sd0, 16'sd331
    };

    // coefficient of a tap, given the index of the centre tap
    function automatic logic signed [COEF_W-1:0] coef_for_tap(input int tap, input int half);
        int m;
        int am;
        logic [OFFSET_W-1:0] idx;
        logic signed [COEF_W-1:0] c;
        m   = tap - half;
        am  = (m < 0) ? -m : m;
        idx = am[OFFSET_W-1:0];
        c   = ODD_COEF[idx];
        if (m < 0)
        begin
            c = -c;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hilbert_fir_analytic_signal.sv */
`default_nettype none

// channel   dir  beat fields (low bit first)          handshake
// s_axis    in   s_tdata: sample                       s_tvalid / s_tready
// m_axis    out  m_tdata: real_part, imag_part         m_tvalid / m_tready
//
// one sample per clock sustained while the output is not stalled; an input beat reaches the output beat through
// the cell row's partial-sum registers, then the round and saturate register
// the row of TAPS cells holds both the sample delay line and the transposed
// partial sums; every cell updates on the same input beat
// reset clears the delay line and partial sums to zero
// a stalled output holds its beat; the cell row still takes one more sample
// while the output waits, and s_tready drops only when both stages are full

module hilbert_fir_analytic_signal #(
    parameter int TAPS         = 31,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // sample
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // real_part, imag_part
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        m_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready
);

    localparam int HALF     = TAPS / 2;
    localparam int ACC_W    = hfa_pkg::COEF_W + SAMPLE_WIDTH + $clog2(TAPS);
    localparam int RND_W    = ACC_W + 1 - hfa_pkg::COEF_FRAC;
    localparam int OUT_W    = ((2*SAMPLE_WIDTH+7)/8)*8;

    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [SAMPLE_WIDTH-1:0] tap_w [TAPS];
    logic signed [ACC_W-1:0]        sum_w [TAPS+1];

    logic mid_valid_reg;
    logic mid_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_ready;
    logic cell_en;

    logic signed [SAMPLE_WIDTH-1:0] out_real_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_imag_reg;
    logic signed [SAMPLE_WIDTH-1:0] imag_sat;
    logic signed [ACC_W:0]          acc_biased;
    logic signed [RND_W-1:0]        rnd;
    logic                           sat_hi;
    logic                           sat_lo;

    assign sample = $signed(s_tdata[SAMPLE_WIDTH-1:0]);

    // elastic two-stage flow: cell row, then output register
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !mid_valid_reg || out_ready;
    assign cell_en   = s_tvalid && s_tready;

    // row of cells: taps shift toward higher index, sums flow toward cell zero
    assign sum_w[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        hfa_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH),
            .ACC_W       (ACC_W),
            .COEF        (hfa_pkg::coef_for_tap(k, HALF))
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (cell_en),
            .sample (sample),
            .tap_in ((k == 0) ? sample : tap_w[(k == 0) ? 0 : k-1]),
            .tap_out(tap_w[k]),
            .sum_in (sum_w[k+1]),
            .sum_out(sum_w[k])
        );
    end

    // cell zero's partial sum is the full fir sum; round half up then saturate
    assign acc_biased = (ACC_W+1)'(sum_w[0]) + (ACC_W+1)'(1 << (hfa_pkg::COEF_FRAC - 1));
    assign rnd        = acc_biased[ACC_W:hfa_pkg::COEF_FRAC];
    assign sat_hi     = !rnd[RND_W-1] && (|rnd[RND_W-2:SAMPLE_WIDTH-1]);
    assign sat_lo     = rnd[RND_W-1] && !(&rnd[RND_W-2:SAMPLE_WIDTH-1]);

    always_comb
    begin
        if (sat_hi)
        begin
            imag_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        else if (sat_lo)
        begin
            imag_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            imag_sat = rnd[SAMPLE_WIDTH-1:0];
        end
    end

    // stage valids
    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        if (cell_en)
        begin
            mid_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            mid_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = mid_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload; the centre cell's tap is the delayed real sample
    always_ff @(posedge clk)
    begin
        if (out_ready && mid_valid_reg)
        begin
            out_real_reg <= tap_w[HALF];
            out_imag_reg <= imag_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    // zero fill up to whole bytes
    assign m_tdata  = OUT_W'({out_imag_reg, out_real_reg});

    // an accepted sample always lands in the middle stage
    a_accept_fills_mid: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> mid_valid_reg)
    else $error("accepted sample did not reach the cell row stage");

    // a blocked middle stage keeps its sum
    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && !out_ready |=> mid_valid_reg && $stable(sum_w[0]))
    else $error("middle stage lost or changed its sum while blocked");

    // a new output beat only comes from a filled middle stage
    a_out_from_mid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(mid_valid_reg))
    else $error("output beat without a source");

    // no input taken while both stages are full and the output is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted into a full pipeline");

endmodule

`default_nettype wire

/* hw/rtl/hfa_cell.sv */
`default_nettype none

module hfa_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_W        = 37,
    parameter logic signed [hfa_pkg::COEF_W-1:0] COEF = '0
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] tap_in,
    output logic signed [SAMPLE_WIDTH-1:0]      tap_out,
    input  wire logic signed [ACC_W-1:0]        sum_in,
    output logic signed [ACC_W-1:0]             sum_out
);

    localparam int PROD_W = hfa_pkg::COEF_W + SAMPLE_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] tap_reg;
    logic signed [SAMPLE_WIDTH-1:0] tap_next;
    logic signed [ACC_W-1:0]        sum_reg;
    logic signed [ACC_W-1:0]        sum_next;
    logic signed [PROD_W-1:0]       prod;

    // transposed-form tap: product of the new sample plus the upstream partial sum
    assign prod     = COEF * sample;
    assign sum_next = ACC_W'(prod) + sum_in;
    assign tap_next = tap_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            sum_reg <= '0;
        end
        else if (en)
        begin
            tap_reg <= tap_next;
            sum_reg <= sum_next;
        end
    end

    assign tap_out = tap_reg;
    assign sum_out = sum_reg;

endmodule

`default_nettype wire
